[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of the search table.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

[hw/rtl/sost_pkg.sv]
// Package of the self-organizing search table: sizes, codes and control structs.
// No dependencies; used by sost_cell, sost_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sost_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int POS_W       = 4;
	localparam int CNT_W       = 5;
	localparam int DATA_W      = 32;
	localparam int MODE_W      = 2;
	localparam int OIDX_W      = 4;
	localparam int CMP_W       = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
	localparam int PCMP_W      = (IDX_W > POS_W) ? IDX_W : POS_W;
	localparam int S_TDATA_W   = ((POS_W + DATA_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((1 + OIDX_W + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_PLAIN = 2'd1,
		MODE_TRANS = 2'd2,
		MODE_MTF   = 2'd3
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESOLVE
	} state_t;

	typedef struct packed {
		logic accept;
		logic resolve;
	} seq_t;

	typedef struct packed {
		logic              load;
		logic              search;
		logic              do_trans;
		logic              do_mtf;
		logic              any_hit;
		logic [POS_W-1:0]  pos;
		logic [CNT_W-1:0]  limit;
		logic [DATA_W-1:0] key;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/sost_cell.sv]
// One table cell: holds an entry, compares it with the key and swaps with a neighbor or with the head.
// Depends on sost_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sost_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [sost_pkg::IDX_W-1:0] cell_idx,
	input  wire sost_pkg::cell_ctl_t       ctl,
	input  wire logic [sost_pkg::DATA_W-1:0] prev_data,
	input  wire logic [sost_pkg::DATA_W-1:0] head_data,
	input  wire logic                      hit_in,
	input  wire logic                      next_first,
	output logic      [sost_pkg::DATA_W-1:0] data,
	output logic                           hit_out,
	output logic                           first
);

	logic [sost_pkg::DATA_W-1:0] data_q;
	logic                        match_q;
	logic                        in_use;
	logic                        sel;
	logic                        is_head;

	assign in_use  = sost_pkg::CMP_W'(cell_idx) < sost_pkg::CMP_W'(ctl.limit);
	assign sel     = sost_pkg::PCMP_W'(cell_idx) == sost_pkg::PCMP_W'(ctl.pos);
	assign is_head = (cell_idx == '0);
	assign first   = match_q & ~hit_in;
	assign hit_out = hit_in | match_q;
	assign data    = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.load || ctl.search) begin
			match_q <= ctl.search & in_use & (data_q == ctl.key);
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.load && sel) begin
			data_q <= ctl.key;
		end else if (ctl.do_trans && first && !is_head) begin
			data_q <= prev_data;
		end else if (ctl.do_trans && next_first) begin
			data_q <= ctl.key;
		end else if (ctl.do_mtf && first && !is_head) begin
			data_q <= head_data;
		end else if (ctl.do_mtf && is_head && ctl.any_hit && !first) begin
			data_q <= ctl.key;
		end else begin
			data_q <= data_q;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sost_ctrl.sv]
// Sequencer of the search table: accept, resolve and output word handshake.
// Depends on sost_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sost_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire logic      m_tready,
	output logic           m_tvalid,
	output sost_pkg::seq_t seq
);

	sost_pkg::state_t state_q;
	sost_pkg::state_t state_d;
	logic             m_valid_q;
	logic             ready;

	assign ready    = (state_q == sost_pkg::ST_IDLE) && (!m_valid_q || m_tready);
	assign s_tready = ready;
	assign m_tvalid = m_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sost_pkg::ST_IDLE: begin
				if (s_tvalid && ready) begin
					state_d = sost_pkg::ST_RESOLVE;
				end
			end
			sost_pkg::ST_RESOLVE: begin
				state_d = sost_pkg::ST_IDLE;
			end
			default: begin
				state_d = sost_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		seq = '0;
		unique case (state_q)
			sost_pkg::ST_IDLE: begin
				seq.accept = s_tvalid && ready;
			end
			sost_pkg::ST_RESOLVE: begin
				seq.resolve = 1'b1;
			end
			default: begin
				seq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sost_pkg::ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (seq.resolve) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/self_organizing_search_table.sv]
// Self-organizing search table: one input word gives one output word.
// Input word: s_tuser = mode (0 load, 1 plain search, 2 transpose, 3 move-to-head);
//   s_tdata = position, then the key or entry data. Output word: found, match index.
// cfg_we / cfg_data set entries_in_use, the count of entries searched from
//   entry 0; write it only while no word is in flight.
// For each word, at the accept edge every cell compares its entry
//   with the key (a load writes its entry), and at the next edge the first-hit
//   chain across the cells picks the match, the swap is done and the result is
//   registered. The sequencer is then idle again and can take a new word.
// The result register lets the next word be accepted while a result waits, as
//   long as m_tready takes it by the accept edge; while m_tready stays low the
//   block holds the result and takes no new word.
// Reset clears the count and the sequencer; entries hold nothing valid until
//   loaded, and a search must not reach an entry never loaded.
// Depends on sost_pkg, sost_cell and sost_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module self_organizing_search_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sost_pkg::CNT_W-1:0]     cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [3:0] position, [35:4] search_value, [39:36] zero
	input  wire logic [sost_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] mode
	input  wire logic [sost_pkg::MODE_W-1:0]    s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [0] found, [4:1] match_index, [7:5] zero
	output logic      [sost_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int N = sost_pkg::TABLE_DEPTH;

	sost_pkg::seq_t              seq;
	sost_pkg::cell_ctl_t         ctl;
	logic [sost_pkg::CNT_W-1:0]  limit_q;
	logic [sost_pkg::DATA_W-1:0] key_q;
	logic [sost_pkg::POS_W-1:0]  pos_q;
	sost_pkg::mode_t             mode_q;
	sost_pkg::mode_t             in_mode;
	logic                        found_q;
	logic [sost_pkg::OIDX_W-1:0] idx_q;
	logic [sost_pkg::DATA_W-1:0] cell_data [N];
	logic [N:0]                  hit;
	logic [N-1:0]                first;
	logic [sost_pkg::IDX_W-1:0]  hit_idx;

	assign in_mode = sost_pkg::mode_t'(s_tuser);

	sost_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.seq      (seq)
	);

	always_comb begin
		ctl          = '0;
		ctl.load     = seq.accept && (in_mode == sost_pkg::MODE_LOAD);
		ctl.search   = seq.accept && (in_mode != sost_pkg::MODE_LOAD);
		ctl.do_trans = seq.resolve && (mode_q == sost_pkg::MODE_TRANS);
		ctl.do_mtf   = seq.resolve && (mode_q == sost_pkg::MODE_MTF);
		ctl.any_hit  = hit[N];
		ctl.pos      = s_tdata[sost_pkg::POS_W-1:0];
		ctl.limit    = limit_q;
		ctl.key      = seq.accept ? s_tdata[sost_pkg::POS_W +: sost_pkg::DATA_W] : key_q;
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		sost_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (sost_pkg::IDX_W'(i)),
			.ctl        (ctl),
			.prev_data  (cell_data[(i == 0) ? 0 : i - 1]),
			.head_data  (cell_data[0]),
			.hit_in     (hit[i]),
			.next_first ((i == N - 1) ? 1'b0 : first[(i == N - 1) ? i : i + 1]),
			.data       (cell_data[i]),
			.hit_out    (hit[i+1]),
			.first      (first[i])
		);
	end

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < N; i++) begin
			hit_idx = hit_idx | (first[i] ? sost_pkg::IDX_W'(i) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.accept) begin
			key_q  <= s_tdata[sost_pkg::POS_W +: sost_pkg::DATA_W];
			pos_q  <= s_tdata[sost_pkg::POS_W-1:0];
			mode_q <= in_mode;
		end
		if (seq.resolve) begin
			if (mode_q == sost_pkg::MODE_LOAD) begin
				found_q <= 1'b0;
				idx_q   <= pos_q;
			end else begin
				found_q <= hit[N];
				idx_q   <= sost_pkg::OIDX_W'(hit_idx);
			end
		end
	end

	assign m_tdata = sost_pkg::M_TDATA_W'({idx_q, found_q});

endmodule

`default_nettype wire

[hw/rtl/sost_checker.sv]
// Port-level checker of the search table, bound to the top level below.
// Depends on assert_macros.svh and sost_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sost_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [sost_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic [sost_pkg::MODE_W-1:0]    s_tuser,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [sost_pkg::M_TDATA_W-1:0] m_tdata
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output word changed")
	`ASSERT_CLK(a_one_in_flight, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second word accepted while busy")
	`ASSERT_CLK(a_latency, clk, arst_n, s_tvalid && s_tready |-> ##2 m_tvalid, "result not shown two cycles after accept")
	`ASSERT_CLK(a_load_echo, clk, arst_n, s_tvalid && s_tready && (s_tuser == sost_pkg::MODE_LOAD) |-> ##2 (!m_tdata[0] && (m_tdata[4:1] == $past(s_tdata[3:0], 2))), "load result does not echo position")

endmodule

bind self_organizing_search_table sost_checker u_sost_checker (.*);

`default_nettype wire

[bench/tb_self_organizing_search_table.sv]
`timescale 1ns / 1ps
// Testbench for self_organizing_search_table: directed and random load/search words
// checked against an in-bench table that mirrors the reordering. Uses sost_pkg and the top level.

module tb_self_organizing_search_table;

	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic                        found;
		logic [sost_pkg::OIDX_W-1:0] idx;
	} lookup_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [sost_pkg::CNT_W-1:0]     cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [sost_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [sost_pkg::MODE_W-1:0]    s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [sost_pkg::M_TDATA_W-1:0] m_tdata;

	logic [sost_pkg::DATA_W-1:0] entry_copy [sost_pkg::TABLE_DEPTH];
	bit                          loaded [sost_pkg::TABLE_DEPTH];
	int unsigned                 entry_count;
	lookup_result_t              pending_results [$];
	bit                          no_idle;
	int                          words_checked, mismatches, loads_sent, searches_sent, hits_seen;
	int                          settings_used;

	self_organizing_search_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES,
			pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word found=%0b idx=%0d", $time, m_tdata[0],
					m_tdata[4:1]);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				words_checked++;
				if (m_tdata[0] !== want.found) begin
					$display("%0t: found mismatch, expected %0b actual %0b", $time,
						want.found, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[4:1] !== want.idx) begin
					$display("%0t: match_index mismatch, expected %0d actual %0d", $time,
						want.idx, m_tdata[4:1]);
					mismatches++;
				end
			end
		end
	end

	function automatic void swap_entries(int a, int b);
		logic [sost_pkg::DATA_W-1:0] t;
		t = entry_copy[a];
		entry_copy[a] = entry_copy[b];
		entry_copy[b] = t;
	endfunction

	function automatic int search_span();
		return (entry_count > sost_pkg::TABLE_DEPTH) ? sost_pkg::TABLE_DEPTH : entry_count;
	endfunction

	function automatic bit search_is_safe();
		bit ok;
		ok = 1'b1;
		for (int i = 0; i < search_span(); i++)
			if (!loaded[i])
				ok = 1'b0;
		return ok;
	endfunction

	function automatic lookup_result_t predict_lookup(sost_pkg::mode_t mode,
			logic [sost_pkg::POS_W-1:0] pos, logic [sost_pkg::DATA_W-1:0] key);
		lookup_result_t r;
		int hit_at;
		r = '0;
		if (mode == sost_pkg::MODE_LOAD) begin
			entry_copy[pos] = key;
			loaded[pos] = 1'b1;
			r.idx = pos;
			return r;
		end
		hit_at = -1;
		for (int i = 0; i < search_span(); i++)
			if (hit_at < 0 && entry_copy[i] == key)
				hit_at = i;
		if (hit_at >= 0) begin
			r.found = 1'b1;
			r.idx = hit_at[sost_pkg::OIDX_W-1:0];
			hits_seen++;
			if (hit_at > 0 && mode == sost_pkg::MODE_TRANS)
				swap_entries(hit_at, hit_at - 1);
			else if (hit_at > 0 && mode == sost_pkg::MODE_MTF)
				swap_entries(hit_at, 0);
		end
		return r;
	endfunction

	task automatic send_word(sost_pkg::mode_t mode, logic [sost_pkg::POS_W-1:0] pos,
			logic [sost_pkg::DATA_W-1:0] val);
		int gap;
		if (!no_idle && $urandom_range(99) < 23) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {{(sost_pkg::S_TDATA_W - sost_pkg::DATA_W - sost_pkg::POS_W){1'b0}},
			val, pos};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (mode == sost_pkg::MODE_LOAD)
			loads_sent++;
		else
			searches_sent++;
		pending_results.push_back(predict_lookup(mode, pos, val));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_count(logic [sost_pkg::CNT_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		entry_count = value;
		settings_used++;
	endtask

	// Count is zero after reset: searches see nothing, table still unwritten.
	task automatic test_empty_count();
		send_word(sost_pkg::MODE_PLAIN, 4'hF, 32'h0000_0000);
		send_word(sost_pkg::MODE_TRANS, 4'h0, 32'hFFFF_FFFF);
		send_word(sost_pkg::MODE_MTF, 4'hA, 32'h8000_0000);
	endtask

	task automatic test_load_table();
		logic [sost_pkg::DATA_W-1:0] v;
		set_count(5'd16);
		for (int i = 0; i < sost_pkg::TABLE_DEPTH; i++) begin
			case (i)
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'h0000_0000;
				3: v = 32'hFFFF_FFFF;
				4: v = 32'hAAAA_AAAA;
				5: v = 32'h5555_5555;
				12: v = 32'h0000_1006;
				default: v = 32'h0000_1000 + i;
			endcase
			send_word(sost_pkg::MODE_LOAD, i[sost_pkg::POS_W-1:0], v);
		end
	endtask

	task automatic test_search_modes();
		send_word(sost_pkg::MODE_PLAIN, 4'h3, 32'h5555_5555);
		send_word(sost_pkg::MODE_PLAIN, 4'hC, 32'h1234_5678);
		send_word(sost_pkg::MODE_TRANS, 4'h0, 32'h8000_0000);
		send_word(sost_pkg::MODE_TRANS, 4'h0, 32'h0000_1007);
		send_word(sost_pkg::MODE_MTF, 4'h0, entry_copy[0]);
		send_word(sost_pkg::MODE_MTF, 4'h0, 32'h0000_1009);
		send_word(sost_pkg::MODE_PLAIN, 4'h0, 32'h0000_1006);
	endtask

	task automatic test_count_limits();
		set_count(5'd31);
		send_word(sost_pkg::MODE_PLAIN, 4'h0, entry_copy[15]);
		set_count(5'd1);
		send_word(sost_pkg::MODE_PLAIN, 4'h0, entry_copy[15]);
		send_word(sost_pkg::MODE_TRANS, 4'h0, entry_copy[0]);
		send_word(sost_pkg::MODE_MTF, 4'h5, 32'h0BAD_F00D);
	endtask

	task automatic random_word();
		sost_pkg::mode_t             mode;
		logic [sost_pkg::POS_W-1:0]  pos;
		logic [sost_pkg::DATA_W-1:0] val;
		int                          pick;
		pos = sost_pkg::POS_W'($urandom_range(0, sost_pkg::TABLE_DEPTH - 1));
		pick = $urandom_range(99);
		if (pick < 20)
			mode = sost_pkg::MODE_LOAD;
		else
			mode = sost_pkg::mode_t'($urandom_range(1, 3));
		if (mode == sost_pkg::MODE_LOAD) begin
			case ($urandom_range(0, 5))
				0: val = 32'h8000_0000;
				1: val = 32'h7FFF_FFFF;
				2, 3: val = 32'h0000_1000 + $urandom_range(0, 5);
				default: val = $urandom;
			endcase
		end else if ($urandom_range(99) < 70) begin
			val = entry_copy[$urandom_range(0, sost_pkg::TABLE_DEPTH - 1)];
		end else if ($urandom_range(1)) begin
			val = 32'h0000_1000 + $urandom_range(0, 5);
		end else begin
			val = $urandom;
		end
		if (mode != sost_pkg::MODE_LOAD && !search_is_safe())
			mode = sost_pkg::MODE_LOAD;
		send_word(mode, pos, val);
	endtask

	task automatic test_random();
		logic [sost_pkg::CNT_W-1:0] phase_counts [10];
		phase_counts = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0, 5'd16, 5'd20, 5'd12, 5'd2, 5'd16};
		for (int p = 0; p < 10; p++) begin
			set_count(phase_counts[p]);
			no_idle = (p == 5);
			for (int n = 0; n < 130; n++) begin
				if (p == 3 && n == 65)
					wait_drained();
				random_word();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < sost_pkg::TABLE_DEPTH; i++) begin
			entry_copy[i] = '0;
			loaded[i] = 1'b0;
		end
		entry_count = 0;
		no_idle = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_empty_count();
		test_load_table();
		test_search_modes();
		test_count_limits();
		test_random();
		wait_drained();
		$display("Checked %0d result words: %0d loads, %0d searches, %0d hits",
			words_checked, loads_sent, searches_sent, hits_seen);
		$display("Table size written %0d times, from zero through above-depth", settings_used);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sost_pkg.sv
hw/rtl/sost_cell.sv
hw/rtl/sost_ctrl.sv
hw/rtl/self_organizing_search_table.sv
hw/rtl/sost_checker.sv
bench/tb_self_organizing_search_table.sv
